>>> design/aft_pkg.sv
// Shared types and constants for the ACES filmic tone-map block.
package aft_pkg;

  // Default channel format: unsigned Q8.16
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned INTEGER_BITS_DEF  = 8;

  // One lane per color channel
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PIX_BITS  = 8;
  localparam int unsigned OUT_W     = NUM_LANES * PIX_BITS;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYPASS_ENABLE = 2'd0,
    CFG_BG_RED        = 2'd1,
    CFG_BG_GREEN      = 2'd2,
    CFG_BG_BLUE       = 2'd3
  } cfg_reg_t;

  // Result of one lane for one pixel
  typedef struct packed {
    logic                valid;
    logic                byp;
    logic [PIX_BITS-1:0] pix;
  } lane_out_t;

endpackage

>>> design/aces_filmic_tone_map.sv
// Top level of the ACES filmic tone-map block: config registers, bypass match, lanes, output.
//
// Maps one HDR pixel (three unsigned Q(INTEGER_BITS).(FRACTION_BITS) channels) per clock
// to three display bytes using x(2.51x+0.03)/(x(2.43x+0.59)+0.14), truncated to
// FRACTION_BITS fraction bits, clamped to 1.0 and scaled by 255. A pixel equal to the
// background color while bypass is enabled skips the curve: each channel is clamped to
// 1.0 and scaled the same way, and out_tuser is set. Throughput is one pixel per clock unless
// the output stalls; the per-channel divider resolves one quotient bit per pipeline stage.
// The whole pipeline holds while a finished pixel waits at the output, so in_tready is high
// while the output slot is empty or out_tready is high. Configuration is written through
// cfg_wen/cfg_index/cfg_wdata while no pixel is in flight; the user ensures it, the block does not.
module aces_filmic_tone_map #(
  parameter int unsigned FRACTION_BITS = aft_pkg::FRACTION_BITS_DEF,
  parameter int unsigned INTEGER_BITS  = aft_pkg::INTEGER_BITS_DEF
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  // Input pixel stream
  input  logic                                                       in_tvalid,
  output logic                                                       in_tready,
  // red_in, green_in, blue_in
  input  logic [((3*(FRACTION_BITS+INTEGER_BITS)+7)/8)*8-1:0]        in_tdata,
  // Result stream
  output logic                                                       out_tvalid,
  input  logic                                                       out_tready,
  output logic [aft_pkg::OUT_W-1:0]                                  out_tdata,  // red_byte, green_byte, blue_byte
  output logic                                                       out_tuser,  // was_bypassed
  // Configuration write port
  input  logic                                                       cfg_wen,
  input  logic [aft_pkg::CFG_IDX_W-1:0]                              cfg_index,
  input  logic [FRACTION_BITS+INTEGER_BITS-1:0]                      cfg_wdata
);
  import aft_pkg::*;

  localparam int unsigned CW = FRACTION_BITS + INTEGER_BITS;

  // Configuration registers
  logic          byp_en_r;
  logic [CW-1:0] bg_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_en_r <= 1'b1;
      bg_r[0]  <= '0;
      bg_r[1]  <= '0;
      bg_r[2]  <= CW'(1) << FRACTION_BITS;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_BYPASS_ENABLE: byp_en_r <= cfg_wdata[0];
        CFG_BG_RED:        bg_r[0]  <= cfg_wdata;
        CFG_BG_GREEN:      bg_r[1]  <= cfg_wdata;
        CFG_BG_BLUE:       bg_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel split and background match
  logic [CW-1:0] chan [NUM_LANES];
  logic          skip;
  logic          en;
  logic          in_acc;

  always_comb begin
    skip = byp_en_r;
    for (int i = 0; i < NUM_LANES; i++) begin
      chan[i] = in_tdata[i*CW +: CW];
      skip    = skip && (chan[i] == bg_r[i]);
    end
  end

  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  // Channel lanes
  lane_out_t lane_out [NUM_LANES];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    aft_lane #(
      .FRAC_BITS (FRACTION_BITS),
      .INT_BITS  (INTEGER_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (in_acc),
      .in_byp   (skip),
      .in_chan  (chan[i]),
      .out_o    (lane_out[i])
    );
  end

  // Output register
  aft_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_i     (lane_out),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Lane consistency checks
  aft_merge_unused_guard u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .lane_i (lane_out)
  );

endmodule

>>> design/aft_lane.sv
// One channel lane: curve numerator/denominator, pipelined restoring divide, byte conversion.
module aft_lane #(
  parameter int unsigned FRAC_BITS = aft_pkg::FRACTION_BITS_DEF,
  parameter int unsigned INT_BITS  = aft_pkg::INTEGER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_byp,
  input  logic [FRAC_BITS+INT_BITS-1:0] in_chan,
  output aft_pkg::lane_out_t            out_o
);
  import aft_pkg::*;

  localparam int unsigned CW = FRAC_BITS + INT_BITS;
  localparam int unsigned EW = CW + 4;             // room to compare against 8.0
  localparam int unsigned XS = FRAC_BITS + 3;      // channel below 8.0
  localparam int unsigned DW = 2 * FRAC_BITS + 15; // numerator / denominator
  localparam int unsigned FW = FRAC_BITS + 1;      // value in [0, 1.0]
  localparam int unsigned PW = FRAC_BITS + 9;      // value times 255

  // Input classification
  logic [EW-1:0]   x_e;
  logic            big;
  logic            over1;
  logic [XS-1:0]   xs;
  logic [2*XS-1:0] sq;
  logic [FW-1:0]   fv_in;

  assign x_e   = EW'(in_chan);
  assign big   = x_e >= (EW'(8) << FRAC_BITS);
  assign over1 = x_e >= (EW'(1) << FRAC_BITS);
  assign xs    = XS'(x_e);
  assign sq    = xs * xs;
  // forced value: 1.0 on saturation, clamped channel on bypass
  assign fv_in = over1 ? (FW'(1) << FRAC_BITS) : FW'(x_e);

  // Stage 1: square
  logic            vld1_r;
  logic            byp1_r;
  logic            fix1_r;
  logic [FW-1:0]   fv1_r;
  logic [XS-1:0]   x1_r;
  logic [2*XS-1:0] sq1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      byp1_r <= in_byp;
      fix1_r <= big | in_byp;
      fv1_r  <= fv_in;
      x1_r   <= xs;
      sq1_r  <= sq;
    end
  end

  // Stage 2: num = 251x^2 + 3Sx, den = 243x^2 + 59Sx + 14S^2
  logic [DW-1:0] sqd;
  logic [DW-1:0] xsh;
  logic [DW-1:0] num;
  logic [DW-1:0] den;

  assign sqd = DW'(sq1_r);
  assign xsh = DW'(x1_r) << FRAC_BITS;
  assign num = DW'(251) * sqd + DW'(3) * xsh;
  assign den = DW'(243) * sqd + DW'(59) * xsh + (DW'(14) << (2 * FRAC_BITS));

  // Divider stage registers; index 0 holds num/den, index k holds k quotient bits
  logic                 vld_r [FRAC_BITS+1];
  logic                 byp_r [FRAC_BITS+1];
  logic                 fix_r [FRAC_BITS+1];
  logic [FW-1:0]        fv_r  [FRAC_BITS+1];
  logic [DW-1:0]        rem_r [FRAC_BITS+1];
  logic [DW-1:0]        den_r [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld1_r;
      byp_r[0] <= byp1_r;
      fix_r[0] <= fix1_r;
      fv_r[0]  <= fv1_r;
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [DW:0]   rs;
    logic          ge;
    logic          fix_k;
    logic [DW-1:0] rem_nxt;

    assign rs      = {rem_r[k], 1'b0};
    assign ge      = rs >= {1'b0, den_r[k]};
    assign rem_nxt = ge ? DW'(rs - {1'b0, den_r[k]}) : DW'(rs);

    // first stage also catches a quotient of 1.0 or more
    if (k == 0) begin : g_first
      assign fix_k = fix_r[k] | (rem_r[k] >= den_r[k]);
    end else begin : g_rest
      assign fix_k = fix_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
        byp_r[k+1] <= byp_r[k];
        fix_r[k+1] <= fix_k;
        fv_r[k+1]  <= fv_r[k];
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= {quo_r[k][FRAC_BITS-2:0], ge};
      end
    end
  end

  // Byte conversion: floor(v * 255 / S)
  logic [FW-1:0] v;
  logic [PW-1:0] v255;
  lane_out_t     out_r;

  assign v    = fix_r[FRAC_BITS] ? fv_r[FRAC_BITS] : {1'b0, quo_r[FRAC_BITS]};
  assign v255 = (PW'(v) << 8) - PW'(v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r.valid <= vld_r[FRAC_BITS];
      out_r.byp   <= byp_r[FRAC_BITS];
      out_r.pix   <= v255[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
    end
  end

  assign out_o = out_r;

  // Restoring divide leaves a remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[FRAC_BITS] && !fix_r[FRAC_BITS]) |-> (rem_r[FRAC_BITS] < den_r[FRAC_BITS]))
    else $error("lane remainder not below divisor");

  // A stalled lane holds its result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && out_r.valid) |=> (out_r.valid && $stable(out_r.pix) && $stable(out_r.byp)))
    else $error("lane result changed during stall");

endmodule

>>> design/aft_merge.sv
// Output stage: joins the three lane results into one pixel transaction.
module aft_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aft_pkg::lane_out_t                   lane_i [aft_pkg::NUM_LANES],
  output logic                                 en_o,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [aft_pkg::OUT_W-1:0]            out_tdata,  // red_byte, green_byte, blue_byte
  output logic                                 out_tuser   // was_bypassed
);
  import aft_pkg::*;

  logic             valid_r;
  logic [OUT_W-1:0] data_r;
  logic             user_r;
  logic [OUT_W-1:0] data_nxt;

  // Pipeline moves whenever the output slot is free or being emptied
  assign en_o = !valid_r || out_tready;

  // Pack lane bytes, red lowest
  always_comb begin
    data_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      data_nxt[i*PIX_BITS +: PIX_BITS] = lane_i[i].pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_o) begin
      valid_r <= lane_i[0].valid;
      data_r  <= data_nxt;
      user_r  <= lane_i[0].byp;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

>>> design/aft_merge_unused_guard.sv
// Lane agreement checker for the three channel lanes.
module aft_merge_unused_guard (
  input logic               clk,
  input logic               rst_n,
  input aft_pkg::lane_out_t lane_i [aft_pkg::NUM_LANES]
);
  import aft_pkg::*;

  // All lanes carry the same pixel at the same time
  a_lanes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_i[0].valid == lane_i[1].valid) && (lane_i[0].valid == lane_i[2].valid))
    else $error("lanes out of step");

  // Bypass decision is shared by all lanes of a pixel
  a_lanes_byp: assert property (@(posedge clk) disable iff (!rst_n)
    lane_i[0].valid |-> ((lane_i[0].byp == lane_i[1].byp) && (lane_i[0].byp == lane_i[2].byp)))
    else $error("lanes disagree on bypass");

  // A valid pixel carries fully known bytes and bypass flag
  a_lanes_known: assert property (@(posedge clk) disable iff (!rst_n)
    lane_i[0].valid |->
      !$isunknown({lane_i[0].pix, lane_i[1].pix, lane_i[2].pix, lane_i[0].byp}))
    else $error("lane result has unknown bits");

endmodule

>>> test/tb.sv
// Testbench for the ACES filmic tone-map block: directed, random and backpressure tests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aft_pkg::*;

  localparam int unsigned FRAC       = FRACTION_BITS_DEF;
  localparam int unsigned CHAN_W     = FRACTION_BITS_DEF + INTEGER_BITS_DEF;
  localparam int unsigned IN_W       = ((3 * CHAN_W + 7) / 8) * 8;
  localparam logic [16:0] ONE_FX     = 17'h10000;
  localparam logic [23:0] SAT_LEVEL  = 24'h080000;  // 8.0: curve is above 1 from here on
  localparam int unsigned LATENCY    = FRAC + 4;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam longint unsigned LIMIT_NS = 24_000_000;

  typedef logic [CHAN_W-1:0] chan_t;

  // Packed so that red sits in the lowest bits, as on in_tdata
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // Expected display bytes of one pixel
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bypassed;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;   // red_byte, green_byte, blue_byte
  logic                out_tuser;   // was_bypassed
  logic                cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHAN_W-1:0]   cfg_wdata = '0;

  // Register copy used for prediction
  logic   bypass_on = 1'b1;
  pixel_t background = '{blue: 24'h010000, green: 24'h0, red: 24'h0};

  shade_t shade_q[$];
  shade_t want;
  int     mismatches = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_pick;
  int unsigned hold_cnt = 0;
  logic        hold_req = 1'b0;

  aces_filmic_tone_map u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Curve level v = floor(S * x(251x+3S) / (x(243x+59S)+14S^2)), clamped to 1.0
  function automatic logic [16:0] curve_level(chan_t x);
    logic [63:0]  xw;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [95:0]  quo;
    xw = {40'd0, x};
    if (x >= SAT_LEVEL) return ONE_FX;
    num = xw * (64'd251 * xw + 64'd3 * 64'd65536);
    den = xw * (64'd243 * xw + 64'd59 * 64'd65536) + 64'd14 * 64'd65536 * 64'd65536;
    if (num >= den) return ONE_FX;
    quo = ({32'd0, num} << FRAC) / {32'd0, den};
    return quo[16:0];
  endfunction

  function automatic logic [7:0] display_byte(logic [16:0] v);
    logic [24:0] prod;
    if (v > ONE_FX) v = ONE_FX;
    prod = v * 25'd255;
    return prod[FRAC+7:FRAC];
  endfunction

  function automatic logic [16:0] clamp_one(chan_t x);
    return (x > ONE_FX) ? ONE_FX : x[16:0];
  endfunction

  function automatic shade_t tone_map_pixel(pixel_t px);
    shade_t s;
    s.bypassed = bypass_on && (px == background);
    if (s.bypassed) begin
      s.red   = display_byte(clamp_one(px.red));
      s.green = display_byte(clamp_one(px.green));
      s.blue  = display_byte(clamp_one(px.blue));
    end else begin
      s.red   = display_byte(curve_level(px.red));
      s.green = display_byte(curve_level(px.green));
      s.blue  = display_byte(curve_level(px.blue));
    end
    return s;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len(int unsigned pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic chan_t rand_channel();
    case ($urandom_range(7, 0))
      0, 1, 2: return $urandom_range(24'h03FFFF, 0);
      3:       return $urandom_range(24'h090000, 24'h070000);
      4:       return $urandom_range(24'h00FFFF, 0);
      5:       return chan_t'(1) << $urandom_range(CHAN_W - 1, 0);
      default: return chan_t'($urandom());
    endcase
  endfunction

  // Send one pixel; returns at the edge where the transaction completes
  task automatic send_pixel(chan_t r, chan_t g, chan_t b);
    int unsigned gap;
    pixel_t      px;
    px = '{blue: b, green: g, red: r};
    gap = idle_len(tx_idle_pct);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    shade_q.push_back(tone_map_pixel(px));
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, chan_t data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BYPASS_ENABLE: bypass_on = data[0];
      CFG_BG_RED:        background.red = data;
      CFG_BG_GREEN:      background.green = data;
      CFG_BG_BLUE:       background.blue = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_background(chan_t r, chan_t g, chan_t b);
    cfg_write(CFG_BG_RED, r);
    cfg_write(CFG_BG_GREEN, g);
    cfg_write(CFG_BG_BLUE, b);
  endtask

  // Zero, full scale, the saturation edge at 8.0 and the point where f(x) crosses 1
  task automatic test_curve_extremes();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_pixel(24'h000000, 24'h000000, 24'h000000);
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'h000001, 24'h010000, SAT_LEVEL);
    send_pixel(24'h07FFFF, 24'h073E00, 24'h074000);
    send_pixel(24'h008000, 24'h020000, 24'h00FFFF);
    send_pixel(24'h800000, 24'h7FFFFF, 24'h400000);
    wait_idle();
  endtask

  // Background match, near misses, channels above 1.0, and bypass turned off
  task automatic test_bypass();
    send_pixel(24'h000000, 24'h000000, 24'h010000);
    send_pixel(24'h000000, 24'h000000, 24'h010001);
    send_pixel(24'h000001, 24'h000000, 24'h010000);
    wait_idle();
    set_background(24'hFFFFFF, 24'h012345, 24'h000000);
    send_pixel(24'hFFFFFF, 24'h012345, 24'h000000);
    send_pixel(24'hFFFFFF, 24'h012344, 24'h000000);
    wait_idle();
    set_background(24'h000000, 24'h000000, 24'h000000);
    send_pixel(24'h000000, 24'h000000, 24'h000000);
    wait_idle();
    set_background(24'h00FFFF, 24'h008000, 24'h000001);
    send_pixel(24'h00FFFF, 24'h008000, 24'h000001);
    wait_idle();
    cfg_write(CFG_BYPASS_ENABLE, 24'h000000);
    send_pixel(24'h00FFFF, 24'h008000, 24'h000001);
    wait_idle();
    cfg_write(CFG_BYPASS_ENABLE, 24'h000001);
  endtask

  // Random pixels; a share of them equal the background or miss it by one bit
  task automatic test_random_pixels(int unsigned count, int unsigned match_pct);
    logic [IN_W-1:0] raw;
    pixel_t          px;
    repeat (count) begin
      if ($urandom_range(99, 0) < match_pct) begin
        raw = background;
        if ($urandom_range(1, 0) == 1) begin
          raw[$urandom_range(IN_W - 1, 0)] ^= 1'b1;
        end
        px = raw;
      end else begin
        px = '{blue: rand_channel(), green: rand_channel(), red: rand_channel()};
      end
      send_pixel(px.red, px.green, px.blue);
    end
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while pixels keep coming
  task automatic test_output_holdoff();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    test_random_pixels(200, 20);
  endtask

  // Result receiver with random idling and a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      hold_cnt   <= 0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_req   <= 1'b0;
      hold_cnt   <= HOLD_CYCLES - 1;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap     <= rx_gap - 1;
    end else begin
      rx_pick = idle_len(rx_idle_pct);
      out_tready <= (rx_pick == 0);
      rx_gap     <= (rx_pick == 0) ? 0 : rx_pick - 1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (shade_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = shade_q.pop_front();
        if (out_tdata[7:0] !== want.red) begin
          $display("%0t: red_byte expected %0d actual %0d", $time, want.red, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[15:8] !== want.green) begin
          $display("%0t: green_byte expected %0d actual %0d", $time, want.green,
                   out_tdata[15:8]);
          mismatches++;
        end
        if (out_tdata[23:16] !== want.blue) begin
          $display("%0t: blue_byte expected %0d actual %0d", $time, want.blue,
                   out_tdata[23:16]);
          mismatches++;
        end
        if (out_tuser !== want.bypassed) begin
          $display("%0t: was_bypassed expected %b actual %b", $time, want.bypassed,
                   out_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_curve_extremes();
    test_bypass();

    // Reset background, moderate idling on both sides
    set_background(24'h000000, 24'h000000, 24'h010000);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    test_random_pixels(400, 15);

    // Bypass off, no idling at all
    cfg_write(CFG_BYPASS_ENABLE, 24'h000000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_pixels(300, 15);

    // Random background, heavy idling
    cfg_write(CFG_BYPASS_ENABLE, 24'hFFFFFF);
    set_background(chan_t'($urandom()), rand_channel(), rand_channel());
    tx_idle_pct = 50;
    rx_idle_pct = 50;
    test_random_pixels(400, 20);

    // Full-scale background, receiver mostly stalling
    set_background(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    tx_idle_pct = 10;
    rx_idle_pct = 60;
    test_random_pixels(300, 20);

    set_background(rand_channel(), rand_channel(), rand_channel());
    test_output_holdoff();

    wait_idle();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && shade_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d results outstanding", $time, shade_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
